>>> design/dependency_task_selector_top_defines.svh
// Assertion macros shared by the dependency task selector RTL.
`ifndef DEPENDENCY_TASK_SELECTOR_TOP_DEFINES_SVH
`define DEPENDENCY_TASK_SELECTOR_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define DTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define DTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/dts_pkg.sv
// Shared types and constants of the dependency task selector.
`default_nettype none

package dts_pkg;

  localparam int unsigned MaskW            = 32;
  localparam int unsigned TaskMax          = 32;
  localparam int unsigned TaskCountDefault = 32;

  typedef logic [MaskW-1:0] mask_t;

  typedef enum logic [2:0] {
    REQ_ENABLE  = 3'd0,
    REQ_DISABLE = 3'd1,
    REQ_CLEAR   = 3'd2,
    REQ_SWITCH  = 3'd3,
    REQ_SELECT  = 3'd4,
    REQ_RUN     = 3'd5,
    REQ_LOAD    = 3'd6
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_TDENTS = 2'd0,
    KIND_TDEPS  = 2'd1,
    KIND_DIRECT = 2'd2
  } table_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EN_PICK,
    ST_EN_USE,
    ST_SD_PICK,
    ST_SD_USE,
    ST_SP_PICK,
    ST_SP_USE,
    ST_RUN_PICK,
    ST_RUN_USE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> design/dts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/dts_ffs.sv
// Lowest-set-bit finder used by the sequencer to pick the next task.
`default_nettype none

module dts_ffs #(
  parameter int unsigned Width = 32,
  localparam int unsigned IdxW = (Width > 1) ? $clog2(Width) : 1
) (
  input  wire logic [Width-1:0] vec_i,
  output logic                  found_o,
  output logic      [IdxW-1:0]  idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = Width - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        idx_o = IdxW'(i);
      end
    end
  end

  assign found_o = |vec_i;

endmodule

`default_nettype wire

>>> design/dependency_task_selector_top.sv
// Top level of the dependency task selector: request sequencer, masks and tables.
//
// Channels: one request stream in (s_axis_*), one result stream out (m_axis_*).
// Each request gives exactly one result. Request kind travels on s_axis_tuser_i.
// Requests are taken only while the sequencer is idle (s_axis_tready_o high).
//
// Work per request, from the accepting edge to the edge that loads the result
// register: an enable with no new request, disable, clear, switch, load, unused
// codes and a select with nothing pending go straight to the result. An enable
// that adds requests first walks every task in the set. A select with pending
// requests walks each disable request, then each candidate task. A run walks
// each task that runs, after that select walk when a select is pending. The
// next request is taken in the cycle after the result is loaded. Each step
// picks the lowest set bit and reads one table word (registered read), folded
// in the next cycle: one read port.
//
// Reset clears requests, selected set, pending flag and the result valid.
// The three tables are not cleared and must be loaded before they are used.
// A result waits in the output register while the receiver stalls; the next
// request is still taken and worked on, and it waits for the register to free.
`include "dependency_task_selector_top_defines.svh"
`default_nettype none

module dependency_task_selector_top
  import dts_pkg::*;
#(
  parameter int unsigned TASK_COUNT = TaskCountDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // request stream
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata: task_mask[31:0], success_mask[63:32], table_task[68:64],
  //        table_kind[70:69], zero pad[71]
  input  wire logic [71:0]  s_axis_tdata_i,
  // tuser: req_type[2:0]
  input  wire logic [2:0]   s_axis_tuser_i,
  // result stream
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // tdata: disable_set[31:0], enable_set[63:32], events[95:64],
  //        selected_set[127:96], pending[128], zero pad[135:129]
  output logic      [135:0] m_axis_tdata_o
);

  // Tasks live in the low bits of a 32-bit mask; larger counts are capped.
  localparam int unsigned TaskNum = (TASK_COUNT > TaskMax) ? TaskMax : TASK_COUNT;
  localparam int unsigned IdxW    = (TaskNum > 1) ? $clog2(TaskNum) : 1;
  localparam mask_t       AllTasks = (TaskNum >= MaskW) ? '1 :
                                     mask_t'((64'd1 << TaskNum) - 64'd1);

  // Request fields
  logic        in_fire;
  req_type_e   in_type;
  mask_t       in_set;
  mask_t       in_succ;
  logic [4:0]  in_task;
  logic [1:0]  in_kind;
  logic        in_range;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_type  = req_type_e'(s_axis_tuser_i);
  assign in_set   = s_axis_tdata_i[31:0] & AllTasks;
  assign in_succ  = s_axis_tdata_i[63:32];
  assign in_task  = s_axis_tdata_i[68:64];
  assign in_kind  = s_axis_tdata_i[70:69];
  assign in_range = 32'(in_task) < 32'(TaskNum);

  // Sequencer and working registers
  state_e    state_q, state_d;
  req_type_e op_q, op_d;
  mask_t     en_req_q, en_req_d;
  mask_t     dis_req_q, dis_req_d;
  mask_t     sel_q, sel_d;
  logic      dirty_q, dirty_d;
  mask_t     work_q, work_d;     // bits still to walk
  mask_t     acc_q, acc_d;       // select candidates, then run schedule
  mask_t     ran_q, ran_d;
  mask_t     ev_q, ev_d;
  mask_t     dis_set_q, dis_set_d;
  mask_t     en_set_q, en_set_d;
  mask_t     task_q, task_d;     // initial set for run
  mask_t     succ_q, succ_d;
  mask_t     bit_q, bit_d;       // task being run

  // Result register
  logic      out_valid_q;
  logic      out_load;
  mask_t     out_dis_q, out_en_q, out_ev_q, out_sel_q;
  logic      out_pend_q;

  // Shared pick unit: lowest set bit, drives the table read address
  logic      ffs_found;
  logic [IdxW-1:0] ffs_idx;
  mask_t     ffs_vec;
  mask_t     pick_bit;

  assign ffs_vec  = (state_q == ST_RUN_PICK) ? acc_q : work_q;
  assign pick_bit = mask_t'(1) << ffs_idx;

  dts_ffs #(
    .Width (TaskNum)
  ) u_ffs (
    .vec_i   (ffs_vec[TaskNum-1:0]),
    .found_o (ffs_found),
    .idx_o   (ffs_idx)
  );

  // Tables: written by load requests, read one word per step
  logic  we_tdents, we_tdeps, we_direct;
  logic  load_ok;
  mask_t tdents_rd, tdeps_rd, direct_rd;

  assign load_ok   = in_fire && (in_type == REQ_LOAD) && in_range;
  assign we_tdents = load_ok && (in_kind == KIND_TDENTS);
  assign we_tdeps  = load_ok && (in_kind == KIND_TDEPS);
  assign we_direct = load_ok && (in_kind == KIND_DIRECT);

  dts_ram #(.Width(MaskW), .Depth(TaskNum)) u_tdents (
    .clk_i   (clk_i),
    .we_i    (we_tdents),
    .waddr_i (in_task[IdxW-1:0]),
    .wdata_i (in_set),
    .raddr_i (ffs_idx),
    .rdata_o (tdents_rd)
  );

  dts_ram #(.Width(MaskW), .Depth(TaskNum)) u_tdeps (
    .clk_i   (clk_i),
    .we_i    (we_tdeps),
    .waddr_i (in_task[IdxW-1:0]),
    .wdata_i (in_set),
    .raddr_i (ffs_idx),
    .rdata_o (tdeps_rd)
  );

  dts_ram #(.Width(MaskW), .Depth(TaskNum)) u_direct (
    .clk_i   (clk_i),
    .we_i    (we_direct),
    .waddr_i (in_task[IdxW-1:0]),
    .wdata_i (in_set),
    .raddr_i (ffs_idx),
    .rdata_o (direct_rd)
  );

  // Helpers
  logic  en_new;     // enable adds at least one new request
  mask_t sel_req;    // final selected set of a select
  mask_t ran_next;
  logic  sel_end;    // last step of a select walk

  assign en_new   = |(in_set & ~en_req_q);
  assign sel_req  = acc_q & AllTasks;
  assign ran_next = ran_q | bit_q;
  assign sel_end  = (state_q == ST_SP_PICK) && !ffs_found;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_type)
            REQ_ENABLE: state_d = en_new ? ST_EN_PICK : ST_DONE;
            REQ_SELECT: state_d = dirty_q ? ST_SD_PICK : ST_DONE;
            REQ_RUN:    state_d = dirty_q ? ST_SD_PICK : ST_RUN_PICK;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_EN_PICK:  state_d = ffs_found ? ST_EN_USE : ST_DONE;
      ST_EN_USE:   state_d = ST_EN_PICK;
      ST_SD_PICK:  state_d = ffs_found ? ST_SD_USE : ST_SP_PICK;
      ST_SD_USE:   state_d = ST_SD_PICK;
      ST_SP_PICK: begin
        if (ffs_found) begin
          state_d = ST_SP_USE;
        end else begin
          state_d = (op_q == REQ_RUN) ? ST_RUN_PICK : ST_DONE;
        end
      end
      ST_SP_USE:   state_d = ST_SP_PICK;
      ST_RUN_PICK: state_d = ffs_found ? ST_RUN_USE : ST_DONE;
      ST_RUN_USE:  state_d = ST_RUN_PICK;
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_d      = op_q;
    en_req_d  = en_req_q;
    dis_req_d = dis_req_q;
    sel_d     = sel_q;
    dirty_d   = dirty_q;
    work_d    = work_q;
    acc_d     = acc_q;
    ran_d     = ran_q;
    ev_d      = ev_q;
    dis_set_d = dis_set_q;
    en_set_d  = en_set_q;
    task_d    = task_q;
    succ_d    = succ_q;
    bit_d     = bit_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d      = in_type;
          task_d    = in_set;
          succ_d    = in_succ;
          dis_set_d = '0;
          en_set_d  = '0;
          ev_d      = '0;
          ran_d     = '0;
          case (in_type)
            REQ_ENABLE: begin
              if (en_new) begin
                dirty_d   = 1'b1;
                en_req_d  = en_req_q | in_set;
                dis_req_d = dis_req_q & ~in_set;
                work_d    = in_set;
              end
            end
            REQ_DISABLE: begin
              if (|(in_set & ~dis_req_q)) begin
                dirty_d   = 1'b1;
                dis_req_d = dis_req_q | in_set;
                en_req_d  = en_req_q & ~in_set;
              end
            end
            REQ_CLEAR: begin
              if (|((en_req_q | dis_req_q) & in_set)) begin
                dirty_d   = 1'b1;
                en_req_d  = en_req_q & ~in_set;
                dis_req_d = dis_req_q & ~in_set;
              end
            end
            REQ_SWITCH: begin
              // clear of everything, then enable; no disable request survives
              // the clear, so the dependency walk has nothing to remove
              if (|(en_req_q | dis_req_q) || |in_set) begin
                dirty_d = 1'b1;
              end
              en_req_d  = in_set;
              dis_req_d = '0;
            end
            REQ_SELECT, REQ_RUN: begin
              if (dirty_q) begin
                acc_d  = en_req_q;
                work_d = dis_req_q;
              end else begin
                acc_d = in_set & sel_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EN_PICK: begin
        if (ffs_found) begin
          work_d = work_q & ~pick_bit;
        end
      end
      ST_EN_USE:  dis_req_d = dis_req_q & ~tdeps_rd;
      ST_SD_PICK: begin
        if (ffs_found) begin
          work_d = work_q & ~pick_bit;
        end else begin
          work_d = acc_q;  // snapshot of surviving enable requests
        end
      end
      ST_SD_USE:  acc_d = acc_q & ~tdents_rd;
      ST_SP_PICK: begin
        if (ffs_found) begin
          work_d = work_q & ~pick_bit;
        end else begin
          dis_set_d = ~sel_req & sel_q;
          en_set_d  = sel_req & ~sel_q;
          sel_d     = sel_req;
          dirty_d   = 1'b0;
          acc_d     = task_q & sel_req;
        end
      end
      ST_SP_USE:  acc_d = acc_q | tdeps_rd;
      ST_RUN_PICK: begin
        if (ffs_found) begin
          bit_d = pick_bit;
        end
      end
      ST_RUN_USE: begin
        ran_d = ran_next;
        if (|(succ_q & bit_q)) begin
          ev_d  = ev_q | bit_q;
          acc_d = (acc_q | (direct_rd & sel_q)) & ~ran_next;
        end else begin
          acc_d = acc_q & ~ran_next;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_load        = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // Control and request state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= REQ_ENABLE;
      en_req_q  <= '0;
      dis_req_q <= '0;
      sel_q     <= '0;
      dirty_q   <= 1'b0;
      ran_q     <= '0;
      ev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      en_req_q  <= en_req_d;
      dis_req_q <= dis_req_d;
      sel_q     <= sel_d;
      dirty_q   <= dirty_d;
      ran_q     <= ran_d;
      ev_q      <= ev_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working payload, no reset needed
  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    acc_q     <= acc_d;
    dis_set_q <= dis_set_d;
    en_set_q  <= en_set_d;
    task_q    <= task_d;
    succ_q    <= succ_d;
    bit_q     <= bit_d;
    if (out_load) begin
      out_dis_q  <= dis_set_q;
      out_en_q   <= en_set_q;
      out_ev_q   <= ev_q;
      out_sel_q  <= sel_q;
      out_pend_q <= dirty_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_pend_q, out_sel_q, out_ev_q, out_en_q, out_dis_q};

  // Checks
  `DTS_ASSERT(a_req_disjoint, (en_req_q & dis_req_q) == '0, "enable and disable requests overlap")
  `DTS_ASSERT(a_sel_in_range, (sel_q & ~AllTasks) == '0, "selected set holds a non-task bit")
  `DTS_ASSERT(a_ev_ran, (ev_q & ~ran_q) == '0, "event reported for a task that did not run")
  `DTS_ASSERT_NEXT(a_select_clean, sel_end, !dirty_q, "pending flag left set after select")

endmodule

`default_nettype wire

>>> tb/dts_checker.sv
// Checker for the dependency task selector: predicts each result and compares it.
module dts_checker
  import dts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic      [71:0]  s_axis_tdata_i,
  input  logic      [2:0]   s_axis_tuser_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic      [135:0] m_axis_tdata_i,
  output int unsigned       fault_count_o,
  output int unsigned       owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mask_t disable_set;
    mask_t enable_set;
    mask_t events;
    mask_t selected_set;
    logic  pending;
  } outcome_t;

  // shadow of the block's request masks and tables
  mask_t    enable_req;
  mask_t    disable_req;
  mask_t    selected;
  logic     dirty;
  mask_t    tdents_tbl [TaskMax];
  mask_t    tdeps_tbl  [TaskMax];
  mask_t    direct_tbl [TaskMax];
  outcome_t outcome_q [$];
  int unsigned faults;

  task automatic add_enables(input mask_t set);
    if ((set & ~enable_req) != '0) begin
      dirty = 1'b1;
      enable_req |= set;
      disable_req &= ~set;
      for (int i = 0; i < TaskMax; i++) begin
        if (set[i]) disable_req &= ~tdeps_tbl[i];
      end
    end
  endtask

  task automatic drop_requests(input mask_t set);
    if (((enable_req | disable_req) & set) != '0) begin
      dirty = 1'b1;
      enable_req &= ~set;
      disable_req &= ~set;
    end
  endtask

  // recompute the selected set; nothing moves unless requests changed
  task automatic reselect(output mask_t dropped, output mask_t added);
    mask_t want;
    mask_t seed;
    dropped = '0;
    added   = '0;
    if (dirty) begin
      want = enable_req;
      for (int i = 0; i < TaskMax; i++) begin
        if (disable_req[i]) want &= ~tdents_tbl[i];
      end
      seed = want;
      for (int i = 0; i < TaskMax; i++) begin
        if (seed[i]) want |= tdeps_tbl[i];
      end
      dropped  = ~want & selected;
      added    = want & ~selected;
      selected = want;
      dirty    = 1'b0;
    end
  endtask

  // lowest id first; a task that already ran is never queued again
  function automatic mask_t run_events(input mask_t start, input mask_t succ);
    mask_t queued;
    mask_t done;
    mask_t ev;
    int    id;
    queued = start & selected;
    done   = '0;
    ev     = '0;
    while (queued != '0) begin
      id = 0;
      while (!queued[id]) id++;
      if (succ[id]) begin
        ev[id] = 1'b1;
        queued |= direct_tbl[id] & selected;
      end
      done[id] = 1'b1;
      queued &= ~done;
    end
    return ev;
  endfunction

  task automatic apply_request(input logic [2:0] code, input logic [71:0] body,
                               output outcome_t res);
    mask_t       arg;
    mask_t       succ;
    logic [4:0]  tsk;
    logic [1:0]  tkind;
    arg   = body[31:0];
    succ  = body[63:32];
    tsk   = body[68:64];
    tkind = body[70:69];
    res   = '0;
    case (code)
      REQ_ENABLE:  add_enables(arg);
      REQ_DISABLE: begin
        if ((arg & ~disable_req) != '0) begin
          dirty = 1'b1;
          disable_req |= arg;
          enable_req &= ~arg;
        end
      end
      REQ_CLEAR:   drop_requests(arg);
      REQ_SWITCH: begin
        drop_requests('1);
        add_enables(arg);
      end
      REQ_SELECT:  reselect(res.disable_set, res.enable_set);
      REQ_RUN: begin
        reselect(res.disable_set, res.enable_set);
        res.events = run_events(arg, succ);
      end
      REQ_LOAD: begin
        case (tkind)
          KIND_TDENTS: tdents_tbl[tsk] = arg;
          KIND_TDEPS:  tdeps_tbl[tsk]  = arg;
          KIND_DIRECT: direct_tbl[tsk] = arg;
          default: ;
        endcase
      end
      default: ;
    endcase
    res.selected_set = selected;
    res.pending      = dirty;
  endtask

  task automatic compare_field(input string name, input mask_t want, input mask_t seen);
    if (want !== seen) begin
      if (faults < 10) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, seen);
      end
      faults++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t seen;
    if (!rst_ni) begin
      enable_req  = '0;
      disable_req = '0;
      selected    = '0;
      dirty       = 1'b0;
      faults      = 0;
      outcome_q.delete();
      fault_count_o <= 0;
      owed_o        <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_request(s_axis_tuser_i, s_axis_tdata_i, want);
        outcome_q.push_back(want);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.disable_set  = m_axis_tdata_i[31:0];
        seen.enable_set   = m_axis_tdata_i[63:32];
        seen.events       = m_axis_tdata_i[95:64];
        seen.selected_set = m_axis_tdata_i[127:96];
        seen.pending      = m_axis_tdata_i[128];
        if (outcome_q.size() == 0) begin
          if (faults < 10) $display("%0t ns: result with no request waiting", $time);
          faults++;
        end else begin
          want = outcome_q.pop_front();
          compare_field("disable_set", want.disable_set, seen.disable_set);
          compare_field("enable_set", want.enable_set, seen.enable_set);
          compare_field("events", want.events, seen.events);
          compare_field("selected_set", want.selected_set, seen.selected_set);
          compare_field("pending", {31'b0, want.pending}, {31'b0, seen.pending});
        end
      end
      fault_count_o <= faults;
      owed_o        <= outcome_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, request and result stream drivers, final verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dts_pkg::*;

  // request codes outside the package set; the block must ignore them
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam int RandomItems = 729;
  // covers the slowest request to finish; leave margin
  localparam int TailCycles  = 250;

  logic         clk_i     = 1'b0;
  logic         rst_ni    = 1'b0;
  logic         req_valid = 1'b0;
  logic         req_ready;
  logic [71:0]  req_data  = '0;
  logic [2:0]   req_code  = '0;
  logic         res_valid;
  logic         res_ready = 1'b0;
  logic [135:0] res_data;
  int unsigned  fault_count;
  int unsigned  results_owed;

  // sender burst bookkeeping
  int burst_left = 0;

  // receiver pattern state
  int unsigned cycle_no   = 0;
  int unsigned stall_left = 0;

  always #10 clk_i = ~clk_i;

  dependency_task_selector_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_data),
    .s_axis_tuser_i  (req_code),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data)
  );

  dts_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_i (req_ready),
    .s_axis_tdata_i  (req_data),
    .s_axis_tuser_i  (req_code),
    .m_axis_tvalid_i (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_i  (res_data),
    .fault_count_o   (fault_count),
    .owed_o          (results_owed)
  );

  // Receiver: cycles through four modes so stalls land on every phase of a
  // select or run. Mode 0 never stalls.
  always @(negedge clk_i) begin
    cycle_no++;
    case (cycle_no[9:8])
      2'd0: res_ready <= 1'b1;
      2'd1: res_ready <= $urandom_range(0, 1);
      2'd2: res_ready <= (cycle_no[3:0] < 4'd11);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          res_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 12);
          res_ready <= 1'b0;
        end else begin
          res_ready <= 1'b1;
        end
      end
    endcase
  end

  // few bits set: keeps dependency tables shallow enough to be interesting
  function automatic mask_t sparse_mask();
    return $urandom() & $urandom() & $urandom();
  endfunction

  function automatic mask_t pick_mask();
    case ($urandom_range(0, 6))
      0, 1:    return $urandom();
      2:       return sparse_mask();
      3:       return mask_t'(1) << $urandom_range(0, 31);
      4:       return ~sparse_mask();
      5:       return '0;
      default: return '1;
    endcase
  endfunction

  // One request: optional idle gap at a burst boundary, then hold valid
  // until the block takes it. Valid gets one assignment per falling edge.
  task automatic push_request(input logic [2:0] code, input mask_t arg, input mask_t succ,
                              input logic [4:0] tsk, input logic [1:0] tkind);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        req_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_valid <= 1'b1;
    req_code  <= code;
    req_data  <= {1'b0, tkind, tsk, succ, arg};
    do @(posedge clk_i); while (!req_ready);
  endtask

  // random request with every field random, then shaped by kind
  task automatic push_random();
    logic [2:0] code;
    mask_t      arg;
    mask_t      succ;
    int         pick;
    pick = $urandom_range(0, 99);
    arg  = pick_mask();
    succ = ($urandom_range(0, 3) != 0) ? ($urandom() | $urandom()) : pick_mask();
    if (pick < 22)      code = REQ_ENABLE;
    else if (pick < 36) code = REQ_DISABLE;
    else if (pick < 44) code = REQ_CLEAR;
    else if (pick < 50) code = REQ_SWITCH;
    else if (pick < 62) code = REQ_SELECT;
    else if (pick < 88) code = REQ_RUN;
    else if (pick < 97) code = REQ_LOAD;
    else                code = REQ_UNUSED;
    // table words stay sparse most of the time so selections are not all-or-nothing
    if (code == REQ_LOAD && $urandom_range(0, 3) != 0) arg = sparse_mask();
    push_request(code, arg, succ, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every table word is loaded before any request can read it
    for (int t = 0; t < TaskMax; t++) begin
      push_request(REQ_LOAD, sparse_mask(), $urandom(), 5'(t), KIND_TDENTS);
      push_request(REQ_LOAD, sparse_mask() & $urandom(), $urandom(), 5'(t), KIND_TDEPS);
      push_request(REQ_LOAD, sparse_mask(), $urandom(), 5'(t), KIND_DIRECT);
    end

    // directed: empty select and run, full masks, no-effect requests,
    // ignored loads, unused code, re-scheduling of tasks that already ran
    push_request(REQ_SELECT, '0, '0, '0, KIND_TDENTS);
    push_request(REQ_RUN, '1, '1, '0, KIND_TDENTS);
    push_request(REQ_ENABLE, '1, '0, '1, KIND_NONE);
    push_request(REQ_ENABLE, '1, '0, '0, KIND_TDENTS);
    push_request(REQ_SELECT, '0, '1, '1, KIND_NONE);
    push_request(REQ_RUN, '1, '1, '0, KIND_TDENTS);
    push_request(REQ_RUN, '1, '0, '0, KIND_TDENTS);
    push_request(REQ_DISABLE, 32'h0000_0001, '0, '0, KIND_TDENTS);
    push_request(REQ_DISABLE, 32'h0000_0001, '0, '0, KIND_TDENTS);
    push_request(REQ_CLEAR, '0, '0, '0, KIND_TDENTS);
    push_request(REQ_CLEAR, 32'h8000_0000, '0, '0, KIND_TDENTS);
    push_request(REQ_SWITCH, 32'h0000_FFFF, '0, '0, KIND_TDENTS);
    push_request(REQ_RUN, 32'h0000_0001, '1, '0, KIND_TDENTS);
    push_request(REQ_LOAD, '1, '1, 5'd31, KIND_NONE);
    push_request(REQ_LOAD, '1, '0, 5'd31, KIND_DIRECT);
    push_request(REQ_LOAD, '0, '0, 5'd0, KIND_DIRECT);
    push_request(REQ_UNUSED, '1, '1, '1, KIND_NONE);
    push_request(REQ_ENABLE, '0, '0, '0, KIND_TDENTS);
    push_request(REQ_SWITCH, '1, '0, '0, KIND_TDENTS);
    push_request(REQ_RUN, '1, '1, '0, KIND_TDENTS);
    push_request(REQ_DISABLE, '1, '0, '0, KIND_TDENTS);
    push_request(REQ_SELECT, '0, '0, '0, KIND_TDENTS);
    push_request(REQ_RUN, '1, '1, '0, KIND_TDENTS);
    push_request(REQ_SWITCH, '1, '0, '0, KIND_TDENTS);
    push_request(REQ_RUN, '1, 32'hAAAA_AAAA, '0, KIND_TDENTS);

    repeat (RandomItems) push_random();

    @(negedge clk_i);
    req_valid <= 1'b0;

    // drain, then give a late or extra result time to show up
    while (results_owed != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fault_count == 0 && results_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
